FILE: rtl/depression_fill_priority_flood_unit_assert.svh
// Assertion macros for the depression fill unit.
`ifndef DEPRESSION_FILL_PRIORITY_FLOOD_UNIT_ASSERT_SVH
`define DEPRESSION_FILL_PRIORITY_FLOOD_UNIT_ASSERT_SVH

// same-cycle implication
`define DFPF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DFPF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/dfpf_pkg.sv
// Package: types, codes and neighbor tables for the depression fill unit.
`default_nettype none

package dfpf_pkg;

   localparam int MAX_COLS_DEF  = 256;
   localparam int MAX_ROWS_DEF  = 256;
   localparam int ELEV_BITS_DEF = 32;
   localparam int DIM_RESET     = 256;

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_FILL   = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_CLEAR,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SCAN_NEXT,
      ST_NB_ISSUE,
      ST_NB_CHK,
      ST_NB_NEXT,
      ST_PU_RD,
      ST_PU_CMP,
      ST_POP,
      ST_POP_TOP,
      ST_SD_RD,
      ST_SD_CMP
   } dfpf_state_type;

   // neighbor k: 0 east, then clockwise through south to north-east
   function automatic logic nb_down(input logic [2:0] k);
      return (k == 3'd1) || (k == 3'd2) || (k == 3'd3);
   endfunction

   function automatic logic nb_up(input logic [2:0] k);
      return (k == 3'd5) || (k == 3'd6) || (k == 3'd7);
   endfunction

   function automatic logic nb_right(input logic [2:0] k);
      return (k == 3'd0) || (k == 3'd1) || (k == 3'd7);
   endfunction

   function automatic logic nb_left(input logic [2:0] k);
      return (k == 3'd3) || (k == 3'd4) || (k == 3'd5);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/depression_fill_priority_flood_unit.sv
// Depression fill unit: raster stores, binary min-heap in memory and fill sequencer.
//
// Requests: load, read, fill. A fill first sweeps the processed-mark memory
// over all MAX_COLS*MAX_ROWS cells, during which no request is taken; then it
// scans the grid (read, check and next states per cell, plus the neighbor
// states for each neighbor of a no-data cell), then pops the heap, sifting down
// after each pop and sifting up after each push of a neighbor. All state sits in
// single-port-write memories with registered reads (the heap has two read ports),
// so the heap sift loops set the fill time. The response to a request must be
// taken before the next one enters.
`default_nettype none

`include "depression_fill_priority_flood_unit_assert.svh"

module depression_fill_priority_flood_unit #(
   parameter int MAX_COLS  = dfpf_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS  = dfpf_pkg::MAX_ROWS_DEF,
   parameter int ELEV_BITS = dfpf_pkg::ELEV_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [1:0]         req_command,
   input  wire logic [15:0]        req_cell_index,
   input  wire logic signed [31:0] req_elevation_in,
   input  wire logic               req_nodata_in,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic signed [31:0] rsp_elevation_out,
   output      logic               rsp_nodata_out,
   output      logic               rsp_ack,
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic               csr_index,
   input  wire logic [8:0]         csr_data
);

   localparam int CELLS = MAX_COLS * MAX_ROWS;
   localparam int IB    = $clog2(CELLS);
   localparam int RB    = $clog2(MAX_ROWS);
   localparam int CB    = $clog2(MAX_COLS);
   localparam int RB1   = $clog2(MAX_ROWS + 1);
   localparam int CB1   = $clog2(MAX_COLS + 1);
   localparam int EW    = ELEV_BITS + IB + RB + CB;

   // heap entry: {key, raster index, row, column}
   function automatic logic signed [ELEV_BITS-1:0] key_of(input logic [EW-1:0] e);
      return $signed(e[EW-1 -: ELEV_BITS]);
   endfunction

   // memories
   logic [ELEV_BITS-1:0] elev_mem [CELLS];
   logic                 nd_mem   [CELLS];
   logic                 proc_mem [CELLS];
   logic [EW-1:0]        heap_mem [CELLS];

   dfpf_pkg::dfpf_state_type state_ff, state_in;

   logic [8:0]           gw_ff, gw_in, gh_ff, gh_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_elev_ff, rsp_elev_in;
   logic                 rsp_nd_ff, rsp_nd_in, rsp_ack_ff, rsp_ack_in;
   logic                 rd_ok_ff, rd_ok_in;
   logic [IB-1:0]        scan_idx_ff, scan_idx_in;
   logic [RB-1:0]        scan_row_ff, scan_row_in;
   logic [CB-1:0]        scan_col_ff, scan_col_in;
   logic [IB-1:0]        ctr_idx_ff, ctr_idx_in;
   logic [RB-1:0]        ctr_row_ff, ctr_row_in;
   logic [CB-1:0]        ctr_col_ff, ctr_col_in;
   logic [IB-1:0]        nb_idx_ff, nb_idx_in;
   logic [RB-1:0]        nb_row_ff, nb_row_in;
   logic [CB-1:0]        nb_col_ff, nb_col_in;
   logic [2:0]           k_ff, k_in;
   logic                 seed_ff, seed_in;
   logic [ELEV_BITS-1:0] spill_ff, spill_in;
   logic [IB:0]          hc_ff, hc_in;
   logic [EW-1:0]        item_ff, item_in;
   logic [IB-1:0]        pos_ff, pos_in;
   logic [IB-1:0]        par_ff, par_in;
   logic                 ret_nb_ff, ret_nb_in;
   logic [EW-1:0]        last_ff, last_in;
   logic [IB-1:0]        hole_ff, hole_in;
   logic [IB-1:0]        lidx_ff, lidx_in;

   // memory ports
   logic [IB-1:0]        rd_addr;
   logic [ELEV_BITS-1:0] elev_rd_ff;
   logic                 nd_rd_ff, proc_rd_ff;
   logic                 elev_we, nd_we, proc_we, hp_we;
   logic [IB-1:0]        elev_wa, proc_wa, hp_wa, hp_ra0, hp_ra1;
   logic [ELEV_BITS-1:0] elev_wd;
   logic                 nd_wd, proc_wd;
   logic [EW-1:0]        hp_wd, hp_rd0_ff, hp_rd1_ff;

   // push request into the heap
   logic                 push_req, push_ret;
   logic [ELEV_BITS-1:0] push_key;
   logic [IB-1:0]        push_idx;
   logic [RB-1:0]        push_row;
   logic [CB-1:0]        push_col;

   logic [CB1-1:0]       w_c;
   logic [RB1-1:0]       h_c;
   logic                 req_acc, idx_ok, scan_last, scan_border;
   logic                 go_up, go_down, go_left, go_right, nb_in_grid;
   logic [IB-1:0]        wi, off_r, off_c, nb_idx_c;
   logic [IB:0]          lc;
   logic                 r_valid, take_r;
   logic [EW-1:0]        child;
   logic signed [ELEV_BITS-1:0] rd_elev_s;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != dfpf_pkg::ST_IDLE) || rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign idx_ok    = 32'(req_cell_index) < CELLS;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_elevation_out = rsp_elev_ff;
   assign rsp_nodata_out    = rsp_nd_ff;
   assign rsp_ack           = rsp_ack_ff;
   assign rd_elev_s         = $signed(elev_rd_ff);

   // grid size with out-of-range values clamped
   always_comb begin
      priority if (gw_ff == 9'd0) w_c = CB1'(1);
      else if (32'(gw_ff) > MAX_COLS) w_c = CB1'(MAX_COLS);
      else w_c = CB1'(gw_ff);
      priority if (gh_ff == 9'd0) h_c = RB1'(1);
      else if (32'(gh_ff) > MAX_ROWS) h_c = RB1'(MAX_ROWS);
      else h_c = RB1'(gh_ff);
   end

   assign scan_last   = (32'(scan_row_ff) + 1 == 32'(h_c)) &&
                        (32'(scan_col_ff) + 1 == 32'(w_c));
   assign scan_border = (scan_row_ff == '0) || (scan_col_ff == '0) ||
                        (32'(scan_row_ff) + 1 == 32'(h_c)) ||
                        (32'(scan_col_ff) + 1 == 32'(w_c));

   // neighbor address from the center cell
   assign go_up    = dfpf_pkg::nb_up(k_ff);
   assign go_down  = dfpf_pkg::nb_down(k_ff);
   assign go_left  = dfpf_pkg::nb_left(k_ff);
   assign go_right = dfpf_pkg::nb_right(k_ff);
   assign nb_in_grid = !(go_up && ctr_row_ff == '0) &&
                       !(go_down && 32'(ctr_row_ff) + 1 >= 32'(h_c)) &&
                       !(go_left && ctr_col_ff == '0) &&
                       !(go_right && 32'(ctr_col_ff) + 1 >= 32'(w_c));
   assign wi    = IB'(w_c);
   assign off_r = go_down ? wi : (go_up ? (~wi + IB'(1)) : '0);
   assign off_c = go_right ? IB'(1) : (go_left ? '1 : '0);
   assign nb_idx_c = ctr_idx_ff + off_r + off_c;

   // heap sift-down helpers
   assign lc      = {hole_ff, 1'b1};
   assign r_valid = ({1'b0, lidx_ff} + (IB+1)'(1)) < hc_ff;
   assign take_r  = r_valid && (key_of(hp_rd1_ff) < key_of(hp_rd0_ff));
   assign child   = take_r ? hp_rd1_ff : hp_rd0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dfpf_pkg::ST_IDLE;
         gw_ff        <= 9'(dfpf_pkg::DIM_RESET);
         gh_ff        <= 9'(dfpf_pkg::DIM_RESET);
         rsp_valid_ff <= 1'b0;
         hc_ff        <= '0;
         seed_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gw_ff        <= gw_in;
         gh_ff        <= gh_in;
         rsp_valid_ff <= rsp_valid_in;
         hc_ff        <= hc_in;
         seed_ff      <= seed_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_elev_ff <= rsp_elev_in;
      rsp_nd_ff   <= rsp_nd_in;
      rsp_ack_ff  <= rsp_ack_in;
      rd_ok_ff    <= rd_ok_in;
      scan_idx_ff <= scan_idx_in;
      scan_row_ff <= scan_row_in;
      scan_col_ff <= scan_col_in;
      ctr_idx_ff  <= ctr_idx_in;
      ctr_row_ff  <= ctr_row_in;
      ctr_col_ff  <= ctr_col_in;
      nb_idx_ff   <= nb_idx_in;
      nb_row_ff   <= nb_row_in;
      nb_col_ff   <= nb_col_in;
      k_ff        <= k_in;
      spill_ff    <= spill_in;
      item_ff     <= item_in;
      pos_ff      <= pos_in;
      par_ff      <= par_in;
      ret_nb_ff   <= ret_nb_in;
      last_ff     <= last_in;
      hole_ff     <= hole_in;
      lidx_ff     <= lidx_in;
   end

   // raster and heap memories
   always_ff @(posedge clock) begin
      if (elev_we) elev_mem[elev_wa] <= elev_wd;
      if (nd_we) nd_mem[elev_wa] <= nd_wd;
      if (proc_we) proc_mem[proc_wa] <= proc_wd;
      if (hp_we) heap_mem[hp_wa] <= hp_wd;
      elev_rd_ff <= elev_mem[rd_addr];
      nd_rd_ff   <= nd_mem[rd_addr];
      proc_rd_ff <= proc_mem[rd_addr];
      hp_rd0_ff  <= heap_mem[hp_ra0];
      hp_rd1_ff  <= heap_mem[hp_ra1];
   end

   always_comb begin
      state_in    = state_ff;
      gw_in       = gw_ff;
      gh_in       = gh_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_elev_in = rsp_elev_ff;
      rsp_nd_in   = rsp_nd_ff;
      rsp_ack_in  = rsp_ack_ff;
      rd_ok_in    = rd_ok_ff;
      scan_idx_in = scan_idx_ff;
      scan_row_in = scan_row_ff;
      scan_col_in = scan_col_ff;
      ctr_idx_in  = ctr_idx_ff;
      ctr_row_in  = ctr_row_ff;
      ctr_col_in  = ctr_col_ff;
      nb_idx_in   = nb_idx_ff;
      nb_row_in   = nb_row_ff;
      nb_col_in   = nb_col_ff;
      k_in        = k_ff;
      seed_in     = seed_ff;
      spill_in    = spill_ff;
      hc_in       = hc_ff;
      item_in     = item_ff;
      pos_in      = pos_ff;
      par_in      = par_ff;
      ret_nb_in   = ret_nb_ff;
      last_in     = last_ff;
      hole_in     = hole_ff;
      lidx_in     = lidx_ff;

      rd_addr  = scan_idx_ff;
      elev_we  = 1'b0;
      elev_wa  = nb_idx_ff;
      elev_wd  = spill_ff;
      nd_we    = 1'b0;
      nd_wd    = req_nodata_in;
      proc_we  = 1'b0;
      proc_wa  = scan_idx_ff;
      proc_wd  = 1'b1;
      hp_we    = 1'b0;
      hp_wa    = hole_ff;
      hp_wd    = last_ff;
      hp_ra0   = '0;
      hp_ra1   = '0;

      push_req = 1'b0;
      push_ret = 1'b0;
      push_key = elev_rd_ff;
      push_idx = nb_idx_ff;
      push_row = nb_row_ff;
      push_col = nb_col_ff;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dfpf_pkg::CSR_GRID_WIDTH:  gw_in = csr_data;
            dfpf_pkg::CSR_GRID_HEIGHT: gh_in = csr_data;
         endcase
      end

      unique case (state_ff)
         dfpf_pkg::ST_IDLE: begin
            rd_addr = IB'(req_cell_index);
            if (req_acc) begin
               rsp_elev_in = '0;
               rsp_nd_in   = 1'b0;
               rsp_ack_in  = 1'b1;
               unique case (req_command)
                  dfpf_pkg::CMD_LOAD: begin
                     elev_we      = idx_ok;
                     nd_we        = idx_ok;
                     elev_wa      = IB'(req_cell_index);
                     elev_wd      = ELEV_BITS'(req_elevation_in);
                     rsp_valid_in = 1'b1;
                  end
                  dfpf_pkg::CMD_FILL: begin
                     scan_idx_in = '0;
                     hc_in       = '0;
                     seed_in     = 1'b1;
                     state_in    = dfpf_pkg::ST_CLEAR;
                  end
                  dfpf_pkg::CMD_READ: begin
                     rd_ok_in = idx_ok;
                     state_in = dfpf_pkg::ST_READ;
                  end
                  default: begin
                     rsp_ack_in   = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         dfpf_pkg::ST_READ: begin
            rsp_elev_in  = rd_ok_ff ? 32'(rd_elev_s) : '0;
            rsp_nd_in    = rd_ok_ff && nd_rd_ff;
            rsp_valid_in = 1'b1;
            state_in     = dfpf_pkg::ST_IDLE;
         end
         dfpf_pkg::ST_CLEAR: begin
            proc_we = 1'b1;
            proc_wd = 1'b0;
            if (32'(scan_idx_ff) == CELLS - 1) begin
               scan_idx_in = '0;
               scan_row_in = '0;
               scan_col_in = '0;
               state_in    = dfpf_pkg::ST_SCAN_RD;
            end else begin
               scan_idx_in = scan_idx_ff + IB'(1);
            end
         end
         dfpf_pkg::ST_SCAN_RD: begin
            state_in = dfpf_pkg::ST_SCAN_CHK;
         end
         dfpf_pkg::ST_SCAN_CHK: begin
            priority if (proc_rd_ff) begin
               state_in = dfpf_pkg::ST_SCAN_NEXT;
            end else if (nd_rd_ff) begin
               proc_we    = 1'b1;
               ctr_idx_in = scan_idx_ff;
               ctr_row_in = scan_row_ff;
               ctr_col_in = scan_col_ff;
               k_in       = '0;
               state_in   = dfpf_pkg::ST_NB_ISSUE;
            end else if (scan_border) begin
               proc_we  = 1'b1;
               push_req = 1'b1;
               push_idx = scan_idx_ff;
               push_row = scan_row_ff;
               push_col = scan_col_ff;
            end else begin
               state_in = dfpf_pkg::ST_SCAN_NEXT;
            end
         end
         dfpf_pkg::ST_SCAN_NEXT: begin
            if (scan_last) begin
               seed_in  = 1'b0;
               state_in = dfpf_pkg::ST_POP;
            end else begin
               scan_idx_in = scan_idx_ff + IB'(1);
               if (32'(scan_col_ff) + 1 == 32'(w_c)) begin
                  scan_col_in = '0;
                  scan_row_in = scan_row_ff + RB'(1);
               end else begin
                  scan_col_in = scan_col_ff + CB'(1);
               end
               state_in = dfpf_pkg::ST_SCAN_RD;
            end
         end
         dfpf_pkg::ST_NB_ISSUE: begin
            rd_addr   = nb_idx_c;
            nb_idx_in = nb_idx_c;
            nb_row_in = ctr_row_ff + RB'(go_down) - RB'(go_up);
            nb_col_in = ctr_col_ff + CB'(go_right) - CB'(go_left);
            state_in  = nb_in_grid ? dfpf_pkg::ST_NB_CHK : dfpf_pkg::ST_NB_NEXT;
         end
         dfpf_pkg::ST_NB_CHK: begin
            proc_wa  = nb_idx_ff;
            push_ret = 1'b1;
            state_in = dfpf_pkg::ST_NB_NEXT;
            if (seed_ff) begin
               if (!proc_rd_ff && !nd_rd_ff) begin
                  proc_we  = 1'b1;
                  push_req = 1'b1;
               end
            end else if (!proc_rd_ff) begin
               proc_we  = 1'b1;
               push_req = 1'b1;
               // cells at or below the spill level are raised to it
               if (rd_elev_s <= $signed(spill_ff)) begin
                  elev_we  = 1'b1;
                  push_key = spill_ff;
               end
            end
         end
         dfpf_pkg::ST_NB_NEXT: begin
            if (k_ff == 3'd7) begin
               state_in = seed_ff ? dfpf_pkg::ST_SCAN_NEXT : dfpf_pkg::ST_POP;
            end else begin
               k_in     = k_ff + 3'd1;
               state_in = dfpf_pkg::ST_NB_ISSUE;
            end
         end
         dfpf_pkg::ST_PU_RD: begin
            hp_ra0 = IB'((pos_ff - IB'(1)) >> 1);
            par_in = IB'((pos_ff - IB'(1)) >> 1);
            if (pos_ff == '0) begin
               hp_we    = 1'b1;
               hp_wa    = '0;
               hp_wd    = item_ff;
               state_in = ret_nb_ff ? dfpf_pkg::ST_NB_NEXT : dfpf_pkg::ST_SCAN_NEXT;
            end else begin
               state_in = dfpf_pkg::ST_PU_CMP;
            end
         end
         dfpf_pkg::ST_PU_CMP: begin
            hp_we = 1'b1;
            hp_wa = pos_ff;
            if (key_of(item_ff) < key_of(hp_rd0_ff)) begin
               hp_wd    = hp_rd0_ff;
               pos_in   = par_ff;
               state_in = dfpf_pkg::ST_PU_RD;
            end else begin
               hp_wd    = item_ff;
               state_in = ret_nb_ff ? dfpf_pkg::ST_NB_NEXT : dfpf_pkg::ST_SCAN_NEXT;
            end
         end
         dfpf_pkg::ST_POP: begin
            hp_ra0 = '0;
            hp_ra1 = IB'(hc_ff - (IB+1)'(1));
            if (hc_ff == '0) begin
               rsp_elev_in  = '0;
               rsp_nd_in    = 1'b0;
               rsp_ack_in   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = dfpf_pkg::ST_IDLE;
            end else begin
               state_in = dfpf_pkg::ST_POP_TOP;
            end
         end
         dfpf_pkg::ST_POP_TOP: begin
            spill_in   = hp_rd0_ff[EW-1 -: ELEV_BITS];
            ctr_idx_in = hp_rd0_ff[RB+CB +: IB];
            ctr_row_in = hp_rd0_ff[CB +: RB];
            ctr_col_in = hp_rd0_ff[0 +: CB];
            last_in    = hp_rd1_ff;
            hc_in      = hc_ff - (IB+1)'(1);
            hole_in    = '0;
            state_in   = dfpf_pkg::ST_SD_RD;
         end
         dfpf_pkg::ST_SD_RD: begin
            hp_ra0  = IB'(lc);
            hp_ra1  = IB'(lc) + IB'(1);
            lidx_in = IB'(lc);
            if (lc >= hc_ff) begin
               hp_we    = 1'b1;
               k_in     = '0;
               state_in = dfpf_pkg::ST_NB_ISSUE;
            end else begin
               state_in = dfpf_pkg::ST_SD_CMP;
            end
         end
         dfpf_pkg::ST_SD_CMP: begin
            hp_we = 1'b1;
            if (key_of(child) < key_of(last_ff)) begin
               hp_wd    = child;
               hole_in  = take_r ? lidx_ff + IB'(1) : lidx_ff;
               state_in = dfpf_pkg::ST_SD_RD;
            end else begin
               k_in     = '0;
               state_in = dfpf_pkg::ST_NB_ISSUE;
            end
         end
         default: state_in = dfpf_pkg::ST_IDLE;
      endcase

      // new entry goes to the heap tail and sifts up
      if (push_req) begin
         item_in   = {push_key, push_idx, push_row, push_col};
         pos_in    = hc_ff[IB-1:0];
         hc_in     = hc_ff + (IB+1)'(1);
         ret_nb_in = push_ret;
         state_in  = dfpf_pkg::ST_PU_RD;
      end
   end

   `DFPF_ASSERT_NOW(a_heap_bound, clock, reset, 1'b1, 32'(hc_ff) <= CELLS, "heap count above capacity")
   `DFPF_ASSERT_NOW(a_pop_nonempty, clock, reset, state_ff == dfpf_pkg::ST_POP_TOP, hc_ff != '0, "pop from empty heap")
   `DFPF_ASSERT_NEXT(a_req_busy, clock, reset, req_acc, rsp_valid_ff || state_ff != dfpf_pkg::ST_IDLE, "request lost")

endmodule

`default_nettype wire

FILE: dv/depression_fill_priority_flood_unit_checker.sv
// Checker: predicts each response of the depression fill unit and compares it.
module depression_fill_priority_flood_unit_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic [15:0]        req_cell_index,
   input  logic signed [31:0] req_elevation_in,
   input  logic               req_nodata_in,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_elevation_out,
   input  logic               rsp_nodata_out,
   input  logic               rsp_ack,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic               csr_index,
   input  logic [8:0]         csr_data,
   output int                 pending,
   output int                 mismatches
);

   typedef struct packed {
      logic signed [31:0] elevation;
      logic               nodata;
      logic               ack;
   } cell_rsp_type;

   localparam int NCELLS = dfpf_pkg::MAX_COLS_DEF * dfpf_pkg::MAX_ROWS_DEF;

   cell_rsp_type       rsp_expected[$];
   logic signed [31:0] terrain[NCELLS];
   bit                 void_cell[NCELLS];
   bit                 visited[NCELLS];
   int                 heap_key[NCELLS];
   int                 heap_cell[NCELLS];
   int                 heap_size;
   logic [8:0]         cols_reg;
   logic [8:0]         rows_reg;

   assign pending = rsp_expected.size();

   initial mismatches = 0;

   task automatic report(input string what, input int got, input int want);
      $display("%0t: response mismatch on %s: got %0d want %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic bit key_lt(input int a, input int b);
      if (heap_key[a] != heap_key[b]) return heap_key[a] < heap_key[b];
      return heap_cell[a] < heap_cell[b];
   endfunction

   function automatic void heap_swap(input int a, input int b);
      int k;
      int c;
      k = heap_key[a];  c = heap_cell[a];
      heap_key[a] = heap_key[b];  heap_cell[a] = heap_cell[b];
      heap_key[b] = k;  heap_cell[b] = c;
   endfunction

   function automatic void spill_push(input int key, input int cell_id);
      int i;
      int p;
      i = heap_size++;
      heap_key[i] = key;
      heap_cell[i] = cell_id;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!key_lt(i, p)) break;
         heap_swap(i, p);
         i = p;
      end
   endfunction

   function automatic void spill_pop(output int key, output int cell_id);
      int i;
      int l;
      int s;
      key = heap_key[0];
      cell_id = heap_cell[0];
      heap_size--;
      heap_key[0] = heap_key[heap_size];
      heap_cell[0] = heap_cell[heap_size];
      i = 0;
      forever begin
         l = 2 * i + 1;
         s = i;
         if (l < heap_size && key_lt(l, s)) s = l;
         if (l + 1 < heap_size && key_lt(l + 1, s)) s = l + 1;
         if (s == i) break;
         heap_swap(i, s);
         i = s;
      end
   endfunction

   function automatic int clamp_dim(input int v, input int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void flood_fill();
      int w;
      int h;
      int r;
      int c;
      int nr;
      int nc;
      int ni;
      int idx;
      int spill;
      int cell_id;
      int dr[8] = '{0, 1, 1, 1, 0, -1, -1, -1};
      int dc[8] = '{1, 1, 0, -1, -1, -1, 0, 1};
      w = clamp_dim(cols_reg, dfpf_pkg::MAX_COLS_DEF);
      h = clamp_dim(rows_reg, dfpf_pkg::MAX_ROWS_DEF);
      foreach (visited[i]) visited[i] = 0;
      heap_size = 0;
      for (r = 0; r < h; r++) begin
         for (c = 0; c < w; c++) begin
            idx = r * w + c;
            if (visited[idx]) continue;
            if (void_cell[idx]) begin
               visited[idx] = 1;
               for (int k = 0; k < 8; k++) begin
                  nr = r + dr[k];
                  nc = c + dc[k];
                  if (nr < 0 || nr >= h || nc < 0 || nc >= w) continue;
                  ni = nr * w + nc;
                  if (visited[ni] || void_cell[ni]) continue;
                  spill_push(terrain[ni], ni);
                  visited[ni] = 1;
               end
            end else if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
               spill_push(terrain[idx], idx);
               visited[idx] = 1;
            end
         end
      end
      while (heap_size > 0) begin
         spill_pop(spill, cell_id);
         r = cell_id / w;
         c = cell_id % w;
         for (int k = 0; k < 8; k++) begin
            nr = r + dr[k];
            nc = c + dc[k];
            if (nr < 0 || nr >= h || nc < 0 || nc >= w) continue;
            ni = nr * w + nc;
            if (visited[ni]) continue;
            visited[ni] = 1;
            if (terrain[ni] <= spill) begin
               terrain[ni] = spill;
               spill_push(spill, ni);
            end else begin
               spill_push(terrain[ni], ni);
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      cell_rsp_type e;
      cell_rsp_type want;
      if (reset) begin
         rsp_expected.delete();
         cols_reg = 9'd256;
         rows_reg = 9'd256;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == dfpf_pkg::CSR_GRID_WIDTH) cols_reg = csr_data;
            else rows_reg = csr_data;
         end
         if (req_valid && !req_stall) begin
            e = '0;
            case (req_command)
               dfpf_pkg::CMD_LOAD: begin
                  terrain[req_cell_index] = req_elevation_in;
                  void_cell[req_cell_index] = req_nodata_in;
                  e.ack = 1'b1;
               end
               dfpf_pkg::CMD_FILL: begin
                  flood_fill();
                  e.ack = 1'b1;
               end
               dfpf_pkg::CMD_READ: begin
                  e.elevation = terrain[req_cell_index];
                  e.nodata = void_cell[req_cell_index];
                  e.ack = 1'b1;
               end
               default: ;
            endcase
            rsp_expected.push_back(e);
         end
         if (rsp_valid && !rsp_stall) begin
            if (rsp_expected.size() == 0) begin
               report("unexpected response", 1, 0);
            end else begin
               want = rsp_expected.pop_front();
               if (rsp_elevation_out !== want.elevation)
                  report("elevation_out", rsp_elevation_out, want.elevation);
               if (rsp_nodata_out !== want.nodata)
                  report("nodata_out", rsp_nodata_out, want.nodata);
               if (rsp_ack !== want.ack)
                  report("ack", rsp_ack, want.ack);
            end
         end
      end
   end
endmodule

FILE: dv/depression_fill_priority_flood_unit_tb.sv
// Testbench top: request stimulus, response stalls, verdict for the depression fill unit.
module depression_fill_priority_flood_unit_tb;

   localparam int CYCLE_LIMIT = 4000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_command = dfpf_pkg::CMD_LOAD;
   logic [15:0]        req_cell_index = '0;
   logic signed [31:0] req_elevation_in = '0;
   logic               req_nodata_in = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_elevation_out;
   logic               rsp_nodata_out;
   logic               rsp_ack;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_index = dfpf_pkg::CSR_GRID_WIDTH;
   logic [8:0]         csr_data = '0;
   int                 pending;
   int                 mismatches;
   int                 cycle_count = 0;
   int                 burst_left = 0;
   bit                 written[65536];
   int                 written_list[$];

   always #4 clock = ~clock;

   depression_fill_priority_flood_unit u_dut (
      .clock, .reset, .req_valid, .req_stall, .req_command, .req_cell_index,
      .req_elevation_in, .req_nodata_in, .rsp_valid, .rsp_stall, .rsp_elevation_out,
      .rsp_nodata_out, .rsp_ack, .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   depression_fill_priority_flood_unit_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_command, .req_cell_index,
      .req_elevation_in, .req_nodata_in, .rsp_valid, .rsp_stall, .rsp_elevation_out,
      .rsp_nodata_out, .rsp_ack, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .pending, .mismatches
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("depression_fill_priority_flood_unit_tb: done, errors");
         $finish;
      end
   end

   // response stall pattern, with one long hold-off to back up the request side
   int stall_mode = 0;
   int mode_left = 0;
   int hold_left = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_done && rsp_valid && cycle_count > 2000) begin
            hold_done <= 1;
            hold_left <= 400;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode <= $urandom_range(0, 2);
               mode_left <= $urandom_range(10, 80);
            end else begin
               mode_left <= mode_left - 1;
            end
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 99) < 30);
               default: rsp_stall <= ($urandom_range(0, 99) < 75);
            endcase
         end
      end
   end

   task automatic send(input logic [1:0] cmd, input int idx, input int elev,
                       input bit nd);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_cell_index <= idx[15:0];
      req_elevation_in <= elev;
      req_nodata_in <= nd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (cmd == dfpf_pkg::CMD_LOAD && !written[idx[15:0]]) begin
         written[idx[15:0]] = 1;
         written_list.push_back(idx[15:0]);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [8:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int terrain_value();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return 32'sh7fffffff;
         2: return 32'sh80000000;
         default: return ($urandom_range(0, 20) - 10) * 1000 + $urandom_range(0, 3);
      endcase
   endfunction

   function automatic int any_written();
      return written_list[$urandom_range(0, written_list.size() - 1)];
   endfunction

   // load a whole grid (unless it is already loaded), poke at it, fill, then read back
   task automatic grid_pass(input logic [8:0] wcfg, input logic [8:0] hcfg, input int nreads,
                            input bit reload);
      int w;
      int h;
      int cells;
      w = (wcfg == 0) ? 1 : (wcfg > 256 ? 256 : wcfg);
      h = (hcfg == 0) ? 1 : (hcfg > 256 ? 256 : hcfg);
      cells = w * h;
      drain();
      csr_write(dfpf_pkg::CSR_GRID_WIDTH, wcfg);
      csr_write(dfpf_pkg::CSR_GRID_HEIGHT, hcfg);
      if (reload) begin
         for (int i = 0; i < cells; i++) begin
            send(dfpf_pkg::CMD_LOAD, i, terrain_value(), $urandom_range(0, 9) == 0);
            if ($urandom_range(0, 15) == 0) send(dfpf_pkg::CMD_READ, any_written(), 0, 0);
         end
      end
      // a few stray requests: at times an unknown command, a load anywhere in the store
      if ($urandom_range(0, 1)) send(dfpf_pkg::CMD_UNUSED, $urandom, $urandom, 1'b1);
      send(dfpf_pkg::CMD_LOAD, $urandom_range(0, 65535), $urandom, $urandom_range(0, 1));
      send(dfpf_pkg::CMD_FILL, $urandom, $urandom, $urandom_range(0, 1));
      for (int i = 0; i < nreads; i++)
         send(dfpf_pkg::CMD_READ, (i < cells) ? i : any_written(), $urandom,
              $urandom_range(0, 1));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: 3x3 pit surrounded by extreme rim values, nodata corner
      csr_write(dfpf_pkg::CSR_GRID_WIDTH, 9'd3);
      csr_write(dfpf_pkg::CSR_GRID_HEIGHT, 9'd3);
      send(dfpf_pkg::CMD_LOAD, 0, 5000, 1'b0);
      send(dfpf_pkg::CMD_LOAD, 1, 32'sh7fffffff, 1'b0);
      send(dfpf_pkg::CMD_LOAD, 2, 32'sh80000000, 1'b1);
      send(dfpf_pkg::CMD_LOAD, 3, 7000, 1'b0);
      send(dfpf_pkg::CMD_LOAD, 4, -100, 1'b0);
      send(dfpf_pkg::CMD_LOAD, 5, 32'sh7fffffff, 1'b0);
      send(dfpf_pkg::CMD_LOAD, 6, 6000, 1'b0);
      send(dfpf_pkg::CMD_LOAD, 7, 32'sh7fffffff, 1'b0);
      send(dfpf_pkg::CMD_LOAD, 8, 32'sh7fffffff, 1'b0);
      send(dfpf_pkg::CMD_LOAD, 16'hffff, 32'sh80000000, 1'b1);
      send(dfpf_pkg::CMD_READ, 4, 0, 0);
      send(dfpf_pkg::CMD_UNUSED, 16'hffff, 32'shffffffff, 1'b1);
      send(dfpf_pkg::CMD_FILL, 0, 0, 0);
      for (int i = 0; i < 9; i++) send(dfpf_pkg::CMD_READ, i, 0, 0);
      send(dfpf_pkg::CMD_READ, 16'hffff, 0, 0);

      // random-index loads and reads over the whole 16-bit index range
      drain();
      for (int i = 0; i < 10; i++)
         send(dfpf_pkg::CMD_LOAD, $urandom_range(0, 65535), $urandom, $urandom_range(0, 1));
      for (int i = 0; i < 10; i++) send(dfpf_pkg::CMD_READ, any_written(), $urandom, 0);

      grid_pass(9'd0, 9'd0, 3, 1'b1);
      grid_pass(9'd511, 9'd1, 10, 1'b1);
      // same 256 cells, already loaded, now taken as one column
      grid_pass(9'd1, 9'd511, 10, 1'b0);
      grid_pass(9'd4, 9'd5, 20, 1'b1);
      grid_pass(9'd7, 9'd3, 21, 1'b1);
      grid_pass(9'd6, 9'd6, 36, 1'b1);
      grid_pass(9'd3, 9'd8, 24, 1'b1);

      drain();
      if (mismatches == 0) begin
         $display("depression_fill_priority_flood_unit_tb: done, clean");
      end else begin
         $display("depression_fill_priority_flood_unit_tb: done, errors");
      end
      $finish;
   end
endmodule
